>>> rtl/lptp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lptp_pkg: shared constants and glyph helpers
// Widths, colors, register indexes and the 3x5 digit font for the LED panel
// test pattern pixel generator.
// ----------------------------------------------------------------------------
package lptp_pkg;

    // Panel geometry. The panel size must be a power of two so that the panel
    // coordinate and the local coordinate are plain bit fields of x and y.
    localparam int PANEL_PX   = 16;
    localparam int PANEL_BITS = $clog2(PANEL_PX);
    localparam int MAX_PANELS = 32;

    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int ROT_W      = 2 * MAX_PANELS;
    localparam int TIME_W     = 32;
    localparam int COLOR_W    = 8;
    localparam int PCOL_W     = COORD_W - PANEL_BITS;
    localparam int PCNT_W     = DIM_W - PANEL_BITS;
    localparam int IDX_W      = PCOL_W + PCNT_W;
    localparam int LOCAL_W    = PANEL_BITS;

    // Stream payload widths.
    localparam int S_DATA_RAW = TIME_W + 2 * COORD_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_W   = 3 * COLOR_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MAP = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 11'd64;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd64;

    // Request kinds carried in tuser.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Colors.
    localparam logic [COLOR_W-1:0] NUM_R    = 8'd255;
    localparam logic [COLOR_W-1:0] NUM_G    = 8'd220;
    localparam logic [COLOR_W-1:0] NUM_B    = 8'd0;
    localparam logic [COLOR_W-1:0] BORDER_R = 8'd40;
    localparam logic [COLOR_W-1:0] BORDER_G = 8'd40;
    localparam logic [COLOR_W-1:0] BORDER_B = 8'd180;
    localparam logic [COLOR_W-1:0] FULL     = 8'd255;

    // Digit and dot placement inside a panel.
    localparam logic [LOCAL_W-1:0] DOT_POS        = 4'd2;
    localparam logic [LOCAL_W-1:0] EDGE_LAST      = LOCAL_W'(PANEL_PX - 1);
    localparam logic [LOCAL_W-1:0] DIGIT_X_UPRIGHT = 4'd6;
    localparam logic [LOCAL_W-1:0] DIGIT_Y_UPRIGHT = 4'd6;
    localparam logic [LOCAL_W-1:0] DIGIT_X_FLIPPED = 4'd7;
    localparam logic [LOCAL_W-1:0] DIGIT_Y_FLIPPED = 4'd5;
    localparam logic [LOCAL_W-1:0] TENS_TOP        = 4'd3;
    localparam logic [LOCAL_W-1:0] UNITS_TOP       = 4'd8;

    // floor(n / 125) = (n * PULSE_RECIP) >> PULSE_SHIFT for any 30-bit n.
    // The pulse period is 500 ms, so n is the elapsed time shifted down by two.
    localparam logic [30:0] PULSE_RECIP = 31'd1099511628;
    localparam int          PULSE_SHIFT = 37;

    // Font: row r of a digit sits in bits [3r+2:3r], the leftmost pixel in
    // the highest bit of the row.
    function automatic logic [14:0] glyph_rows(input logic [3:0] d);
        logic [14:0] g;
        case (d)
            4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    g = {3'd7, 3'd2, 3'd2, 3'd6, 3'd2};
            4'd2:    g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd3:    g = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            4'd4:    g = {3'd1, 3'd1, 3'd7, 3'd5, 3'd5};
            4'd5:    g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd6:    g = {3'd7, 3'd5, 3'd7, 3'd4, 3'd7};
            4'd7:    g = {3'd1, 3'd1, 3'd1, 3'd1, 3'd7};
            4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    g = {3'd7, 3'd1, 3'd7, 3'd5, 3'd7};
            default: g = 15'd0;
        endcase
        return g;
    endfunction

    // True when local pixel (lx,ly) is lit by digit d with its corner at (cx,cy).
    function automatic logic glyph_hit(input logic [LOCAL_W-1:0] lx,
                                       input logic [LOCAL_W-1:0] ly,
                                       input logic [LOCAL_W-1:0] cx,
                                       input logic [LOCAL_W-1:0] cy,
                                       input logic [3:0]         d);
        logic [LOCAL_W-1:0] col;
        logic [LOCAL_W-1:0] row;
        logic [14:0]        rows;
        logic [14:0]        shifted;
        logic               hit;
        col     = lx - cx;
        row     = ly - cy;
        rows    = glyph_rows(d);
        shifted = rows >> (4'(row[2:0]) * 4'd3 + 4'(2'd2 - col[1:0]));
        hit     = 1'b0;
        if (lx >= cx && ly >= cy && col < 4'd3 && row < 4'd5)
        begin
            hit = shifted[0];
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

>>> rtl/led_panel_test_pattern_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_panel_test_pattern_pixel: tiled LED-wall test pattern source
// Draws panel borders, a pulsing dot and the panel number for each pixel
// request, and keeps a wrapping millisecond counter from tick requests.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Signals                      | Content
//  --------+-----------+------------------------------+------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata    | tick or pixel request
//          |           | s_tuser                      |
//  m_      | out       | m_tvalid m_tready m_tdata    | RGB of one pixel request
//  cfg_    | in        | cfg_valid cfg_ready          | frame size and rotation map
//          |           | cfg_index cfg_data           |
//
//  One request is accepted every cycle while the result side keeps up. A pixel
//  request passes the input register, the panel register and the result
//  register before it shows on m_tdata. A tick goes no further than the input
//  register and gives no result. Reset clears the counter, the stage valids
//  and the configuration to 64 x 64 with all panels upright. When m_tready is
//  low the stages fill up and s_tready falls once no stage has a free slot.
//
module led_panel_test_pattern_pixel
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] delta_time_ms, [41:32] pixel_x, [51:42] pixel_y, rest zero
    input  wire logic [lptp_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] operation
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [lptp_pkg::M_DATA_W-1:0]         m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lptp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lptp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lptp_pkg::*;

    // Configuration and time state.
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [ROT_W-1:0]  rotation_map_reg;
    logic [TIME_W-1:0] elapsed_reg;

    // Input stage.
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [TIME_W-1:0]  s1_delta_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;

    // Panel stage.
    logic               s2_valid_reg;
    logic               s2_in_panel_reg;
    logic [LOCAL_W-1:0] s2_lx_reg;
    logic [LOCAL_W-1:0] s2_ly_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic               s2_odd_reg;

    // Result stage.
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_r_reg;
    logic [COLOR_W-1:0] out_g_reg;
    logic [COLOR_W-1:0] out_b_reg;

    logic out_en;
    logic s2_en;
    logic s1_en;

    assign out_en    = !out_valid_reg || m_tready;
    assign s2_en     = !s2_valid_reg || out_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign s_tready  = s1_en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_b_reg, out_g_reg, out_r_reg};

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            rotation_map_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_ROTATION_MAP: rotation_map_reg <= cfg_data[ROT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && s_tvalid)
        begin
            s1_op_reg    <= s_tuser;
            s1_delta_reg <= s_tdata[TIME_W-1:0];
            s1_x_reg     <= s_tdata[TIME_W +: COORD_W];
            s1_y_reg     <= s_tdata[TIME_W + COORD_W +: COORD_W];
        end
    end

    // A tick retires when it leaves the input stage, so a pixel request behind
    // it already sees the new count.
    logic tick_retire;
    assign tick_retire = s1_valid_reg && (s1_op_reg == OP_TICK) && s2_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else if (tick_retire)
        begin
            elapsed_reg <= elapsed_reg + s1_delta_reg;
        end
    end

    // ---------------- panel decode ----------------
    logic [PCNT_W-1:0]     px_count;
    logic [PCNT_W-1:0]     py_count;
    logic [PCOL_W-1:0]     pcol;
    logic [PCOL_W-1:0]     prow;
    logic                  in_panel;
    logic [IDX_W-1:0]      idx0;
    logic [60:0]           pulse_prod;

    assign px_count   = frame_width_reg[DIM_W-1:PANEL_BITS];
    assign py_count   = frame_height_reg[DIM_W-1:PANEL_BITS];
    assign pcol       = s1_x_reg[COORD_W-1:PANEL_BITS];
    assign prow       = s1_y_reg[COORD_W-1:PANEL_BITS];
    assign in_panel   = (PCNT_W'(pcol) < px_count) && (PCNT_W'(prow) < py_count);
    assign idx0       = IDX_W'(prow) * IDX_W'(px_count) + IDX_W'(pcol);
    // Bit PULSE_SHIFT of the product is bit 0 of floor(elapsed / 500).
    assign pulse_prod = 61'(elapsed_reg[TIME_W-1:2]) * 61'(PULSE_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg && (s1_op_reg == OP_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_in_panel_reg <= in_panel;
            s2_lx_reg       <= s1_x_reg[LOCAL_W-1:0];
            s2_ly_reg       <= s1_y_reg[LOCAL_W-1:0];
            s2_idx_reg      <= idx0;
            s2_odd_reg      <= pulse_prod[PULSE_SHIFT];
        end
    end

    // ---------------- pixel color ----------------
    logic [IDX_W:0]     panel_num;
    logic [1:0]         rot;
    logic [LOCAL_W-1:0] cx;
    logic [LOCAL_W-1:0] cy;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [6:0]         units_wide;
    logic [3:0]         units;
    logic               on_border;
    logic               on_dot;
    logic               on_digit;
    logic [COLOR_W-1:0] r_next;
    logic [COLOR_W-1:0] g_next;
    logic [COLOR_W-1:0] b_next;

    assign panel_num  = (IDX_W + 1)'(s2_idx_reg) + 1'b1;
    // Panels past the rotation map are drawn upright.
    assign rot        = (s2_idx_reg < IDX_W'(MAX_PANELS))
                      ? rotation_map_reg[{s2_idx_reg[$clog2(MAX_PANELS)-1:0], 1'b0} +: 2]
                      : 2'd0;
    assign cx         = rot[1] ? DIGIT_X_FLIPPED : DIGIT_X_UPRIGHT;
    assign cy         = rot[1] ? DIGIT_Y_FLIPPED : DIGIT_Y_UPRIGHT;
    // Exact divide by ten for panel numbers below one hundred.
    assign tens_prod  = 15'(panel_num[6:0]) * 15'd205;
    assign tens       = tens_prod[14:11];
    assign units_wide = panel_num[6:0] - 7'(tens) * 7'd10;
    assign units      = units_wide[3:0];

    assign on_border = (s2_lx_reg == '0) || (s2_ly_reg == '0)
                    || (s2_lx_reg == EDGE_LAST) || (s2_ly_reg == EDGE_LAST);
    assign on_dot    = (s2_lx_reg == DOT_POS) && (s2_ly_reg == DOT_POS);

    always_comb
    begin
        on_digit = 1'b0;
        if (panel_num < (IDX_W + 1)'(10))
        begin
            on_digit = glyph_hit(s2_lx_reg, s2_ly_reg, cx, cy, panel_num[3:0]);
        end
        else if (panel_num < (IDX_W + 1)'(100))
        begin
            on_digit = glyph_hit(s2_lx_reg, s2_ly_reg, cx, TENS_TOP, tens)
                    || glyph_hit(s2_lx_reg, s2_ly_reg, cx, UNITS_TOP, units);
        end
    end

    always_comb
    begin
        r_next = '0;
        g_next = '0;
        b_next = '0;
        if (s2_in_panel_reg)
        begin
            if (on_digit)
            begin
                r_next = NUM_R;
                g_next = NUM_G;
                b_next = NUM_B;
            end
            else if (on_dot)
            begin
                r_next = s2_odd_reg ? FULL : '0;
                g_next = s2_odd_reg ? '0 : FULL;
            end
            else if (on_border)
            begin
                r_next = BORDER_R;
                g_next = BORDER_G;
                b_next = BORDER_B;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_r_reg <= r_next;
            out_g_reg <= g_next;
            out_b_reg <= b_next;
        end
    end

    // ---------------- assertions ----------------
    a_tick_adds: assert property (@(posedge clk) disable iff (!rst_n)
        tick_retire |=> elapsed_reg == $past(elapsed_reg + s1_delta_reg))
        else $error("elapsed counter did not advance by the tick delta");

    a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_retire |=> !s2_valid_reg)
        else $error("tick request moved into the panel stage");

    a_free_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register was empty");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: LED panel test pattern pixel generator
// Feeds tick and pixel requests over the input stream and checks every RGB
// result against a color predictor kept beside the block. The frame size and
// rotation map are changed between phases while the block is idle. The
// requesting side works in random bursts and the result side stalls on
// patterns of its own, with one long hold to fill the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    import lptp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 10;
    localparam int FLOOD_ITEMS  = 60;
    localparam int LONG_HOLD    = 300;

    typedef enum int {ROT_0, ROT_90, ROT_180, ROT_270} rot_code_t;
    typedef enum int {READY_ALWAYS, READY_LIGHT, READY_HEAVY, READY_PERIODIC} ready_mode_t;

    class panel_color_board;
        logic [DIM_W-1:0]      width_px;
        logic [DIM_W-1:0]      height_px;
        logic [ROT_W-1:0]      rot_map;
        logic [TIME_W-1:0]     elapsed_ms;
        logic [M_DATA_W-1:0]   pending_colors[$];
        int                    errors;

        function new();
            width_px   = FRAME_WIDTH_RESET;
            height_px  = FRAME_HEIGHT_RESET;
            rot_map    = '0;
            elapsed_ms = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_FRAME_WIDTH)
                width_px = value[DIM_W-1:0];
            else if (idx == REG_FRAME_HEIGHT)
                height_px = value[DIM_W-1:0];
            else if (idx == REG_ROTATION_MAP)
                rot_map = value;
        endfunction

        // Row 0 of a digit sits in the top three bits, leftmost pixel first.
        function bit [14:0] glyph_bits(int d);
            case (d)
                0:       return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
                1:       return {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
                2:       return {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
                3:       return {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
                4:       return {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
                5:       return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
                6:       return {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
                7:       return {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
                8:       return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
                9:       return {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
                default: return '0;
            endcase
        endfunction

        function bit digit_lit(int lx, int ly, int cx, int cy, int d);
            bit [14:0] bits;
            int        col;
            int        row;
            if (d > 9 || lx < cx || ly < cy)
                return 1'b0;
            col = lx - cx;
            row = ly - cy;
            if (col >= 3 || row >= 5)
                return 1'b0;
            bits = glyph_bits(d);
            return bits[14 - 3 * row - col];
        endfunction

        function logic [M_DATA_W-1:0] panel_pixel_color(int x, int y);
            int               cols;
            int               rows;
            int               lx;
            int               ly;
            int               panel;
            int               rot;
            int               cx;
            int               cy;
            logic [COLOR_W-1:0] r;
            logic [COLOR_W-1:0] g;
            logic [COLOR_W-1:0] b;
            cols = int'(width_px) / PANEL_PX;
            rows = int'(height_px) / PANEL_PX;
            r = '0;
            g = '0;
            b = '0;
            if (x / PANEL_PX < cols && y / PANEL_PX < rows)
            begin
                lx    = x % PANEL_PX;
                ly    = y % PANEL_PX;
                panel = (y / PANEL_PX) * cols + x / PANEL_PX + 1;
                rot   = ROT_0;
                // Panels past the rotation map are drawn upright.
                if (panel <= MAX_PANELS)
                    rot = int'((rot_map >> (2 * (panel - 1))) & 64'd3);
                cx = (rot >= ROT_180) ? int'(DIGIT_X_FLIPPED) : int'(DIGIT_X_UPRIGHT);
                cy = (rot >= ROT_180) ? int'(DIGIT_Y_FLIPPED) : int'(DIGIT_Y_UPRIGHT);
                if (lx == 0 || ly == 0 || lx == PANEL_PX - 1 || ly == PANEL_PX - 1)
                begin
                    r = BORDER_R;
                    g = BORDER_G;
                    b = BORDER_B;
                end
                if (lx == int'(DOT_POS) && ly == int'(DOT_POS))
                begin
                    if (((elapsed_ms / 32'd500) & 32'd1) == 32'd0)
                    begin
                        r = '0;
                        g = FULL;
                        b = '0;
                    end
                    else
                    begin
                        r = FULL;
                        g = '0;
                        b = '0;
                    end
                end
                if ((panel < 10 && digit_lit(lx, ly, cx, cy, panel)) ||
                    (panel >= 10 && panel < 100 &&
                     (digit_lit(lx, ly, cx, int'(TENS_TOP), panel / 10) ||
                      digit_lit(lx, ly, cx, int'(UNITS_TOP), panel % 10))))
                begin
                    r = NUM_R;
                    g = NUM_G;
                    b = NUM_B;
                end
            end
            return {b, g, r};
        endfunction

        function void note_request(logic op, logic [TIME_W-1:0] delta,
                                   logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            if (op == OP_TICK)
                elapsed_ms += delta;
            else
                pending_colors.push_back(panel_pixel_color(int'(x), int'(y)));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch: %s got %0d want %0d", what, got, want);
            errors++;
        endtask

        task check_pixel(logic [M_DATA_W-1:0] rgb);
            logic [M_DATA_W-1:0] want;
            if (pending_colors.size() == 0)
            begin
                report_mismatch("result with no pixel request pending", int'(rgb), 0);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (rgb[7:0] !== want[7:0])
                    report_mismatch("red", int'(rgb[7:0]), int'(want[7:0]));
                if (rgb[15:8] !== want[15:8])
                    report_mismatch("green", int'(rgb[15:8]), int'(want[15:8]));
                if (rgb[23:16] !== want[23:16])
                    report_mismatch("blue", int'(rgb[23:16]), int'(want[23:16]));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    panel_color_board board;
    bit               hold_request;
    int               burst_left;

    led_panel_test_pattern_pixel dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input logic op, input logic [TIME_W-1:0] delta,
                                input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - S_DATA_RAW){1'b0}}, y, x, delta};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(op, delta, x, y);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, value);
    endtask

    task automatic configure(input int w, input int h, input logic [ROT_W-1:0] rot);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_ROTATION_MAP, rot);
        cfg_valid <= 1'b0;
    endtask

    // Drops s_tvalid and waits until every pixel result is back, then lets the
    // pipeline drain so a trailing tick also clears before anything else changes.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    function automatic int local_coord();
        // Lean toward the digit area, where most of the detail is.
        return ($urandom_range(0, 1) == 1) ? $urandom_range(0, PANEL_PX - 1)
                                            : $urandom_range(3, 12);
    endfunction

    function automatic logic [TIME_W-1:0] tick_delta();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom;
        else if (pick < 4)
            return $urandom_range(0, 5000);
        return $urandom_range(0, 600);
    endfunction

    task automatic send_random_pixel();
        int cols;
        int rows;
        int pcol;
        int prow;
        int x;
        int y;
        cols = int'(board.width_px) / PANEL_PX;
        rows = int'(board.height_px) / PANEL_PX;
        if (cols > 1024 / PANEL_PX)
            cols = 1024 / PANEL_PX;
        if (rows > 1024 / PANEL_PX)
            rows = 1024 / PANEL_PX;
        if (cols > 0 && rows > 0 && $urandom_range(0, 9) < 7)
        begin
            pcol = $urandom_range(0, cols - 1);
            // Low panel rows carry the numbered panels on large frames.
            prow = ($urandom_range(0, 1) == 1) ? $urandom_range(0, rows - 1)
                                                : $urandom_range(0, (rows < 4 ? rows : 4) - 1);
            x = pcol * PANEL_PX + local_coord();
            y = prow * PANEL_PX + local_coord();
        end
        else
        begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
        end
        send_request(OP_PIXEL, $urandom, COORD_W'(x), COORD_W'(y));
    endtask

    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            pace();
            if ($urandom_range(0, 3) == 0)
                send_request(OP_TICK, tick_delta(), COORD_W'($urandom), COORD_W'($urandom));
            else
                send_random_pixel();
            if ($urandom_range(0, 149) == 0)
                settle();
        end
    endtask

    task automatic directed_items();
        // Reset frame: 4 x 4 upright panels, numbered 1 to 16.
        send_request(OP_PIXEL, 32'hFFFF_FFFF, 10'd0, 10'd0);
        send_request(OP_PIXEL, 32'd0, 10'd1023, 10'd1023);
        send_request(OP_PIXEL, 32'd0, 10'd2, 10'd2);
        send_request(OP_TICK, 32'd500, 10'd1023, 10'd1023);
        send_request(OP_PIXEL, 32'd0, 10'd2, 10'd2);
        // The counter wraps to 499, so the dot turns green again.
        send_request(OP_TICK, 32'hFFFF_FFFF, 10'd0, 10'd0);
        send_request(OP_PIXEL, 32'd0, 10'd18, 10'd2);
        send_request(OP_PIXEL, 32'd0, 10'd15, 10'd15);
        send_request(OP_PIXEL, 32'd0, 10'd63, 10'd63);
        send_request(OP_PIXEL, 32'd0, 10'd7, 10'd6);
        send_request(OP_PIXEL, 32'd0, 10'd6, 10'd6);
        // Panel 10: tens digit from row 3, units digit from row 8.
        send_request(OP_PIXEL, 32'd0, 10'd23, 10'd35);
        send_request(OP_PIXEL, 32'd0, 10'd22, 10'd40);
        send_request(OP_PIXEL, 32'd0, 10'd64, 10'd0);
        send_request(OP_PIXEL, 32'd0, 10'd0, 10'd64);
        send_request(OP_TICK, 32'd0, 10'd0, 10'd0);
        send_request(OP_PIXEL, 32'd0, 10'd1023, 10'd0);
        settle();
        // Largest frame, every panel at 270 degrees.
        configure(1024, 1024, '1);
        send_request(OP_PIXEL, 32'd0, 10'd8, 10'd5);
        send_request(OP_PIXEL, 32'd0, 10'd7, 10'd6);
        // Panel 66 has no rotation bits; panel 100 shows no digits.
        send_request(OP_PIXEL, 32'd0, 10'd22, 10'd22);
        send_request(OP_PIXEL, 32'd0, 10'd567, 10'd22);
        settle();
        configure(64, 64, '0);
    endtask

    task automatic apply_phase(input int k);
        case (k)
            0: configure(1024, 1024, '1);
            1: configure(0, 64, {$urandom, $urandom});
            2: configure(15, 1024, {$urandom, $urandom});
            3: configure(64, 64, {$urandom, $urandom});
            4: configure(160, 1024, {$urandom, $urandom});
            5: configure(1, 1, '0);
            6: configure(2047, 2047, {$urandom, $urandom});
            7: configure($urandom_range(1, 1024), $urandom_range(1, 1024), {$urandom, $urandom});
            8: configure(128, 256, {32{2'b10}});
            default: configure(48, 48, {32{2'b01}});
        endcase
    endtask

    // Result side: random stall patterns, plus one long hold on request.
    initial
    begin : result_side
        int          hold_left;
        int          mode_left;
        int          cycle_ctr;
        ready_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        cycle_ctr = 0;
        mode      = READY_ALWAYS;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_pixel(m_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            cycle_ctr++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
                    READY_HEAVY:    m_tready <= ($urandom_range(0, 9) < 3);
                    default:        m_tready <= (cycle_ctr % 5 != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : requests
        int k;
        board        = new();
        hold_request = 1'b0;
        burst_left   = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_TICK;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        run_random(PHASE_ITEMS);
        settle();
        for (k = 0; k < NUM_PHASES; k++)
        begin
            apply_phase(k);
            if (k == 3)
            begin
                // Hold the result side off and keep offering pixels so the
                // pipeline fills and input requests back up.
                hold_request = 1'b1;
                repeat (FLOOD_ITEMS) send_random_pixel();
            end
            run_random(PHASE_ITEMS);
            settle();
        end
        repeat (SETTLE_WAIT) @(posedge clk);
        if (board.errors == 0 && board.pending_colors.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
